>>> hdl/sha1md_pkg.sv
// Shared types and constants for the SHA-1 message digest core.
// No dependencies; imported by every module of the core.
package sha1md_pkg;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic [31:0] H_INIT [0:4] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam logic [31:0] K_R0 = 32'h5A827999;
    localparam logic [31:0] K_R1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_R2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_R3 = 32'hCA62C1D6;

    localparam logic [6:0] LAST_ROUND = 7'd79;
    localparam logic [2:0] LAST_WORD  = 3'd4;

    // One packed message word on its way to the compression engine.
    typedef struct packed {
        logic [31:0] word;
        logic        last;   // final length word of a message
    } word_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

endpackage

>>> hdl/sha1_message_digest_core.sv
// SHA-1 message digest core, top level. Instantiates sha1md_front,
// sha1md_fifo and sha1md_back; uses sha1md_pkg.
//
// Feed the message one byte per input beat, first byte first. Mark the
// last beat with end_of_message; a beat with no_byte set carries no byte,
// which is how an empty message is ended (a no_byte beat without the end
// mark does nothing). After the last beat the core appends the standard
// padding and 64-bit bit count, then returns the 160-bit digest as five
// output beats, h0 first (word_number 0..4, final_word on the fifth). The
// next message may start right away; its bytes queue up behind the digest.
// Timing: the front end takes one byte per cycle while it is not padding
// and the queue has room, and packs four bytes into a word; a four-word
// queue feeds the compression engine, which shifts in one word per cycle
// while the queue is not empty, then runs the rounds and the chaining add
// before it loads the next block. The single round unit sets the pace.
// Padding adds 9 to 72 pad bytes, then come the last block's rounds, then
// the five digest beats at one per cycle when the sink is ready.
module sha1_message_digest_core
    import sha1md_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        end_of_message,
    input  logic        no_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] digest_word,
    output logic [2:0]  word_number,
    output logic        final_word
);

    fifo_status_t q_status;
    word_entry_t  q_push_data;
    word_entry_t  q_pop_data;
    logic         q_push;
    logic         q_pop;

    // byte intake, word packing and padding
    sha1md_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .end_of_message (end_of_message),
        .no_byte        (no_byte),
        .q_status       (q_status),
        .q_push         (q_push),
        .q_data         (q_push_data)
    );

    // decouples byte intake from the round engine
    sha1md_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .status    (q_status)
    );

    // compression rounds and digest output
    sha1md_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_status    (q_status),
        .q_data      (q_pop_data),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .digest_word (digest_word),
        .word_number (word_number),
        .final_word  (final_word)
    );

endmodule

>>> hdl/sha1md_fifo.sv
// Short word queue between the byte front end and the compression engine.
// Depends on sha1md_pkg.
module sha1md_fifo
    import sha1md_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  word_entry_t  push_data,
    input  logic         pop,
    output word_entry_t  pop_data,
    output fifo_status_t status
);

    word_entry_t          mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]     count_reg, count_next;
    logic                 do_push, do_pop;

    assign status.full  = (count_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign pop_data     = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> hdl/sha1md_front.sv
// Byte front end: takes input beats, packs big-endian words, adds padding
// and the 64-bit length, and pushes words into the queue. Uses sha1md_pkg.
module sha1md_front
    import sha1md_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [7:0]   data_byte,
    input  logic         end_of_message,
    input  logic         no_byte,
    input  fifo_status_t q_status,
    output logic         q_push,
    output word_entry_t  q_data
);

    typedef enum logic [1:0] {S_IN, S_PAD80, S_ZERO, S_LEN} state_t;

    state_t       state_reg, state_next;
    logic [5:0]   pos_reg, pos_next;
    logic [63:0]  bits_reg, bits_next;
    logic [23:0]  word_reg, word_next;
    logic         ins;
    logic [7:0]   ins_byte;
    logic         last_word;
    logic [7:0]   len_byte;

    // length goes out most significant byte first, slots 56..63
    assign len_byte = bits_reg[{~pos_reg[2:0], 3'b000} +: 8];
    assign in_ready = (state_reg == S_IN) && !q_status.full;

    always_comb
    begin
        state_next = state_reg;
        bits_next  = bits_reg;
        ins        = 1'b0;
        ins_byte   = data_byte;
        last_word  = 1'b0;
        unique case (state_reg)
            S_IN:
            begin
                if (in_valid && in_ready)
                begin
                    if (!no_byte)
                    begin
                        ins       = 1'b1;
                        bits_next = bits_reg + 64'd8;
                    end
                    if (end_of_message)
                    begin
                        state_next = S_PAD80;
                    end
                end
            end
            S_PAD80:
            begin
                if (!q_status.full)
                begin
                    ins        = 1'b1;
                    ins_byte   = PAD_BYTE;
                    state_next = (pos_reg == 6'd55) ? S_LEN : S_ZERO;
                end
            end
            S_ZERO:
            begin
                if (!q_status.full)
                begin
                    ins      = 1'b1;
                    ins_byte = 8'h00;
                    if (pos_reg == 6'd55)
                    begin
                        state_next = S_LEN;
                    end
                end
            end
            S_LEN:
            begin
                if (!q_status.full)
                begin
                    ins      = 1'b1;
                    ins_byte = len_byte;
                    if (pos_reg == 6'd63)
                    begin
                        last_word  = 1'b1;
                        bits_next  = '0;
                        state_next = S_IN;
                    end
                end
            end
            default:
            begin
                state_next = S_IN;
            end
        endcase
    end

    assign pos_next    = ins ? pos_reg + 1'b1 : pos_reg;
    assign word_next   = ins ? {word_reg[15:0], ins_byte} : word_reg;
    assign q_push      = ins && (pos_reg[1:0] == 2'b11);
    assign q_data.word = {word_reg, ins_byte};
    assign q_data.last = last_word;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IN;
            pos_reg   <= '0;
            bits_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            bits_reg  <= bits_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

endmodule

>>> hdl/sha1md_back.sv
// Compression engine: loads 16 words from the queue, runs 80 rounds, folds
// into the chaining words; digest out after a last block. Uses sha1md_pkg.
module sha1md_back
    import sha1md_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  fifo_status_t q_status,
    input  word_entry_t  q_data,
    output logic         q_pop,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [31:0]  digest_word,
    output logic [2:0]   word_number,
    output logic         final_word
);

    typedef enum logic [1:0] {S_LOAD, S_ROUND, S_FOLD, S_OUT} state_t;

    state_t       state_reg;
    logic [31:0]  w_reg     [16];
    logic [31:0]  round_reg [5];
    logic [31:0]  chain_reg [5];
    logic [6:0]   t_reg;
    logic [3:0]   cnt_reg;
    logic         final_reg;
    logic [2:0]   out_idx_reg;

    logic [31:0]  a, b, c, d, e;
    logic [31:0]  fn, k, wt, wx, sum;
    logic         shift_en;
    logic [31:0]  shift_in;

    assign a = round_reg[0];
    assign b = round_reg[1];
    assign c = round_reg[2];
    assign d = round_reg[3];
    assign e = round_reg[4];

    // rolling schedule: w_reg[0] is the oldest of the last sixteen words
    assign wx = w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0];
    assign wt = (t_reg < 7'd16) ? w_reg[0] : {wx[30:0], wx[31]};

    always_comb
    begin
        priority if (t_reg < 7'd20)
        begin
            fn = (b & c) | (~b & d);
            k  = K_R0;
        end
        else if (t_reg < 7'd40)
        begin
            fn = b ^ c ^ d;
            k  = K_R1;
        end
        else if (t_reg < 7'd60)
        begin
            fn = (b & c) | (b & d) | (c & d);
            k  = K_R2;
        end
        else
        begin
            fn = b ^ c ^ d;
            k  = K_R3;
        end
    end

    assign sum = {a[26:0], a[31:27]} + fn + e + wt + k;

    assign q_pop    = (state_reg == S_LOAD) && !q_status.empty;
    assign shift_en = q_pop || (state_reg == S_ROUND);
    assign shift_in = q_pop ? q_data.word : wt;

    assign out_valid   = (state_reg == S_OUT);
    assign digest_word = chain_reg[out_idx_reg];
    assign word_number = out_idx_reg;
    assign final_word  = (out_idx_reg == LAST_WORD);

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[15] <= shift_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_LOAD;
            t_reg       <= '0;
            cnt_reg     <= '0;
            final_reg   <= 1'b0;
            out_idx_reg <= '0;
            for (int i = 0; i < 5; i++)
            begin
                round_reg[i] <= '0;
                chain_reg[i] <= H_INIT[i];
            end
        end
        else
        begin
            unique case (state_reg)
                S_LOAD:
                begin
                    if (q_pop)
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                        if (cnt_reg == 4'd15)
                        begin
                            final_reg <= q_data.last;
                            t_reg     <= '0;
                            for (int i = 0; i < 5; i++)
                            begin
                                round_reg[i] <= chain_reg[i];
                            end
                            state_reg <= S_ROUND;
                        end
                    end
                end
                S_ROUND:
                begin
                    round_reg[0] <= sum;
                    round_reg[1] <= a;
                    round_reg[2] <= {b[1:0], b[31:2]};
                    round_reg[3] <= c;
                    round_reg[4] <= d;
                    if (t_reg == LAST_ROUND)
                    begin
                        t_reg     <= '0;
                        state_reg <= S_FOLD;
                    end
                    else
                    begin
                        t_reg <= t_reg + 1'b1;
                    end
                end
                S_FOLD:
                begin
                    for (int i = 0; i < 5; i++)
                    begin
                        chain_reg[i] <= chain_reg[i] + round_reg[i];
                    end
                    out_idx_reg <= '0;
                    state_reg   <= final_reg ? S_OUT : S_LOAD;
                end
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        if (out_idx_reg == LAST_WORD)
                        begin
                            // message done: back to the initial chain
                            out_idx_reg <= '0;
                            state_reg   <= S_LOAD;
                            for (int i = 0; i < 5; i++)
                            begin
                                round_reg[i] <= '0;
                                chain_reg[i] <= H_INIT[i];
                            end
                        end
                        else
                        begin
                            out_idx_reg <= out_idx_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_LOAD;
                end
            endcase
        end
    end

endmodule

>>> hdl/sha1md_checker.sv
// Port-level checks on the digest output beats, bound to the top level.
// Depends on sha1md_pkg and sha1_message_digest_core.
module sha1md_checker
    import sha1md_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] digest_word,
    input logic [2:0]  word_number,
    input logic        final_word
);

    // a stalled digest beat holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(digest_word)
            && $stable(word_number))
        else $error("digest beat changed while stalled");

    a_final_tag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (final_word == (word_number == LAST_WORD)))
        else $error("final_word does not match word_number");

    a_word_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> word_number <= LAST_WORD)
        else $error("word_number out of range");

    // digest words follow each other with no gap, in order
    a_word_seq: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !final_word |=> out_valid
            && (word_number == $past(word_number) + 3'd1))
        else $error("digest words out of sequence");

endmodule

bind sha1_message_digest_core sha1md_checker u_checker (.*);
